### rtl/pcx_pkg.sv
`default_nettype none

package pcx_pkg;

    // Fixed image format constants, default queue depth
    localparam int HEADER_BYTES    = 128;
    localparam int PALETTE_ENTRIES = 256;
    localparam int BOUND_FIRST     = 4;
    localparam int BOUND_END       = 12;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] MAGIC_BYTE   = 8'd10;
    localparam logic [7:0] VERSION_BYTE = 8'd5;
    localparam logic [7:0] RUN_MARK     = 8'hBF;
    localparam logic [7:0] RUN_MASK     = 8'h3F;

    // Request modes
    localparam logic [1:0] MODE_PALETTE = 2'd0;
    localparam logic [1:0] MODE_BYTE    = 2'd1;
    localparam logic [1:0] MODE_OPEN    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC   = 2'd1;
    localparam logic [1:0] ST_BAD_VERSION = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] palette_index;
        logic [7:0] palette_red;
        logic [7:0] palette_green;
        logic [7:0] palette_blue;
        logic [7:0] file_byte;
    } in_item_t;

    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_of_run;
        logic        image_done;
        logic [1:0]  status;
        logic [16:0] image_width;
        logic [16:0] image_height;
    } out_item_t;

    // Commands passed from the front end to the back end
    typedef enum logic [2:0] {
        CMD_PAL,
        CMD_OPEN,
        CMD_FAIL,
        CMD_HDR,
        CMD_PIX
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  index;
        logic [23:0] rgb;
        logic [5:0]  count;
        logic [1:0]  status;
        logic [16:0] width;
        logic [16:0] height;
    } cmd_t;

endpackage

`default_nettype wire

### rtl/pcx_front.sv
`default_nettype none

module pcx_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            src_valid,
    output logic            src_ready,
    input  pcx_pkg::in_item_t src_data,
    output logic            push,
    output pcx_pkg::cmd_t   push_cmd,
    input  logic            queue_full
);
    import pcx_pkg::*;

    logic [7:0]      hdr_pos_reg, hdr_pos_next;
    logic [7:0][7:0] bounds_reg, bounds_next;
    logic            failed_reg, failed_next;
    logic            run_pending_reg, run_pending_next;
    logic [5:0]      run_len_reg, run_len_next;

    logic            accept;
    logic [2:0]      bound_idx;
    logic [15:0]     xmin, xmax, ymin, ymax;
    logic [16:0]     width, height;

    // Image size from the header bounds; inverted bounds give zero
    always_comb
    begin
        xmin   = {bounds_reg[1], bounds_reg[0]};
        ymin   = {bounds_reg[3], bounds_reg[2]};
        xmax   = {bounds_reg[5], bounds_reg[4]};
        ymax   = {bounds_reg[7], bounds_reg[6]};
        width  = (xmax < xmin) ? 17'd0 : ({1'b0, xmax} - {1'b0, xmin} + 17'd1);
        height = (ymax < ymin) ? 17'd0 : ({1'b0, ymax} - {1'b0, ymin} + 17'd1);
    end

    // Classify each request and build the back-end command
    always_comb
    begin
        src_ready        = !queue_full;
        accept           = src_valid && src_ready;
        bound_idx        = 3'(hdr_pos_reg - 8'(BOUND_FIRST));
        hdr_pos_next     = hdr_pos_reg;
        bounds_next      = bounds_reg;
        failed_next      = failed_reg;
        run_pending_next = run_pending_reg;
        run_len_next     = run_len_reg;
        push             = 1'b0;
        push_cmd         = '0;
        push_cmd.kind    = CMD_PIX;
        push_cmd.index   = src_data.file_byte;
        push_cmd.count   = 6'd1;

        if (accept)
        begin
            unique case (src_data.mode)
                MODE_PALETTE:
                begin
                    push           = 1'b1;
                    push_cmd.kind  = CMD_PAL;
                    push_cmd.index = src_data.palette_index;
                    push_cmd.rgb   = {src_data.palette_red, src_data.palette_green,
                                      src_data.palette_blue};
                end
                MODE_OPEN:
                begin
                    push             = 1'b1;
                    push_cmd.kind    = CMD_OPEN;
                    hdr_pos_next     = '0;
                    bounds_next      = '0;
                    failed_next      = 1'b0;
                    run_pending_next = 1'b0;
                    run_len_next     = '0;
                end
                MODE_BYTE:
                begin
                    if (!failed_reg)
                    begin
                        if (hdr_pos_reg < 8'(HEADER_BYTES))
                        begin
                            if (hdr_pos_reg == 8'd0 && src_data.file_byte != MAGIC_BYTE)
                            begin
                                push            = 1'b1;
                                push_cmd.kind   = CMD_FAIL;
                                push_cmd.status = ST_BAD_MAGIC;
                                failed_next     = 1'b1;
                            end
                            else if (hdr_pos_reg == 8'd1 &&
                                     src_data.file_byte != VERSION_BYTE)
                            begin
                                push            = 1'b1;
                                push_cmd.kind   = CMD_FAIL;
                                push_cmd.status = ST_BAD_VERSION;
                                failed_next     = 1'b1;
                            end
                            else
                            begin
                                if (hdr_pos_reg >= 8'(BOUND_FIRST) &&
                                    hdr_pos_reg < 8'(BOUND_END))
                                begin
                                    bounds_next[bound_idx] = src_data.file_byte;
                                end
                                hdr_pos_next = hdr_pos_reg + 8'd1;
                                // last header byte: bounds are complete
                                if (hdr_pos_reg == 8'(HEADER_BYTES - 1))
                                begin
                                    push            = 1'b1;
                                    push_cmd.kind   = CMD_HDR;
                                    push_cmd.width  = width;
                                    push_cmd.height = height;
                                end
                            end
                        end
                        else if (run_pending_reg)
                        begin
                            push             = 1'b1;
                            push_cmd.count   = run_len_reg;
                            run_pending_next = 1'b0;
                        end
                        else if (src_data.file_byte > RUN_MARK)
                        begin
                            run_pending_next = 1'b1;
                            run_len_next     = 6'(src_data.file_byte & RUN_MASK);
                        end
                        else
                        begin
                            push = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg     <= '0;
            bounds_reg      <= '0;
            failed_reg      <= 1'b0;
            run_pending_reg <= 1'b0;
            run_len_reg     <= '0;
        end
        else
        begin
            hdr_pos_reg     <= hdr_pos_next;
            bounds_reg      <= bounds_next;
            failed_reg      <= failed_next;
            run_pending_reg <= run_pending_next;
            run_len_reg     <= run_len_next;
        end
    end

endmodule

`default_nettype wire

### rtl/pcx_queue.sv
`default_nettype none

module pcx_queue #(
    parameter int DEPTH = pcx_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pcx_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output pcx_pkg::cmd_t head,
    output logic          head_valid
);
    import pcx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W:0]   wr_ptr_reg, rd_ptr_reg;

    // Occupancy from wrap-extended pointers
    always_comb
    begin
        full       = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                     (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
        head_valid = (wr_ptr_reg != rd_ptr_reg);
        head       = slots_reg[rd_ptr_reg[PTR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && head_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slots_reg[wr_ptr_reg[PTR_W-1:0]] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/pcx_back.sv
`default_nettype none

module pcx_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pcx_pkg::cmd_t      head,
    input  logic               head_valid,
    output logic               pop,
    output logic               dst_valid,
    input  logic               dst_ready,
    output pcx_pkg::out_item_t dst_data
);
    import pcx_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

    state_t      state_reg, state_next;
    logic [32:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [16:0] width_reg, width_next;
    logic [16:0] height_reg, height_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;
    logic [23:0] rd_data_reg;
    logic [23:0] palette_mem [PALETTE_ENTRIES];

    logic        out_free;
    logic        emitting;
    logic [32:0] rem_eff;
    logic [5:0]  run_n;
    logic        start_run;
    logic [33:0] area;

    // Pop at idle, or alongside the final pixel of a run
    always_comb
    begin
        out_free  = !out_valid_reg || dst_ready;
        emitting  = (state_reg == S_EMIT) && out_free;
        rem_eff   = emitting ? (rem_reg - 33'd1) : rem_reg;
        pop       = head_valid && out_free &&
                    ((state_reg == S_IDLE) ||
                     (cnt_reg == 6'd1 && head.kind != CMD_FAIL && head.kind != CMD_HDR));
        // clamp the run at the pixels left in the image
        run_n     = (rem_eff < 33'(head.count)) ? rem_eff[5:0] : head.count;
        start_run = pop && (head.kind == CMD_PIX) && (rem_eff != 33'd0) &&
                    (head.count != 6'd0);
        area      = 34'(head.width) * 34'(head.height);
        dst_valid = out_valid_reg;
        dst_data  = out_reg;
    end

    // Sequencer next state and result register contents
    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && dst_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (emitting)
        begin
            out_valid_next        = 1'b1;
            out_next              = '0;
            out_next.pixel_valid  = 1'b1;
            out_next.red          = rd_data_reg[23:16];
            out_next.green        = rd_data_reg[15:8];
            out_next.blue         = rd_data_reg[7:0];
            out_next.last_of_run  = (cnt_reg == 6'd1);
            out_next.image_done   = (rem_reg == 33'd1);
            out_next.status       = ST_OK;
            out_next.image_width  = width_reg;
            out_next.image_height = height_reg;
            rem_next              = rem_reg - 33'd1;
            cnt_next              = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                state_next = S_IDLE;
            end
        end

        if (pop)
        begin
            unique case (head.kind)
                CMD_PAL: ;
                CMD_OPEN:
                begin
                    rem_next    = '0;
                    width_next  = '0;
                    height_next = '0;
                end
                CMD_FAIL:
                begin
                    out_valid_next       = 1'b1;
                    out_next             = '0;
                    out_next.last_of_run = 1'b1;
                    out_next.status      = head.status;
                    width_next           = '0;
                    height_next          = '0;
                end
                CMD_HDR:
                begin
                    out_valid_next        = 1'b1;
                    out_next              = '0;
                    out_next.last_of_run  = 1'b1;
                    out_next.image_done   = (area == 34'd0);
                    out_next.status       = ST_OK;
                    out_next.image_width  = head.width;
                    out_next.image_height = head.height;
                    width_next            = head.width;
                    height_next           = head.height;
                    rem_next              = area[32:0];
                end
                CMD_PIX:
                begin
                    if (start_run)
                    begin
                        cnt_next   = run_n;
                        state_next = S_EMIT;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // Palette RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (pop && head.kind == CMD_PAL)
        begin
            palette_mem[head.index] <= head.rgb;
        end
        if (pop)
        begin
            rd_data_reg <= palette_mem[head.index];
        end
    end

endmodule

`default_nettype wire

### rtl/pcx_rle_palette_decoder_unit.sv
`default_nettype none

// PCX 8-bit palettized image decoder. Palette writes, start-of-image and file
// byte requests enter on src; results (header result, failure result, RGB
// pixels) leave on dst. A front parser takes one request per cycle while its
// command queue (QUEUE_DEPTH entries) has room. The back end works one
// command at a time: a literal pixel's command is queued, then popped while
// its palette entry is read, then loaded into the result register; literals
// sustain one per cycle while dst is ready, since the next palette read
// overlaps the current pixel; a run byte emits one result per pixel, up to
// 63. The palette is a 256 x 24 RAM with a registered read port; reading an
// entry never written returns an undefined color. No clearing pass is
// needed after reset.
module pcx_rle_palette_decoder_unit #(
    parameter int QUEUE_DEPTH = pcx_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_ready,
    input  pcx_pkg::in_item_t  src_data,
    output logic               dst_valid,
    input  logic               dst_ready,
    output pcx_pkg::out_item_t dst_data
);
    import pcx_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    cmd_t head;
    logic head_valid;

    pcx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .src_data   (src_data),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    pcx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    pcx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .dst_valid  (dst_valid),
        .dst_ready  (dst_ready),
        .dst_data   (dst_data)
    );

endmodule

`default_nettype wire

### rtl/pcx_checker.sv
`default_nettype none

module pcx_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               dst_valid,
    input logic               dst_ready,
    input pcx_pkg::out_item_t dst_data
);
    import pcx_pkg::*;

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid && $stable(dst_data))
        else $error("result changed while stalled");

    // Header and failure results carry no color and close their request
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_data.pixel_valid |->
            dst_data.last_of_run && dst_data.red == 8'd0 &&
            dst_data.green == 8'd0 && dst_data.blue == 8'd0)
        else $error("non-pixel result malformed");

    // A failure result reports no size and no pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.status != ST_OK |->
            !dst_data.pixel_valid && !dst_data.image_done &&
            dst_data.image_width == 17'd0 && dst_data.image_height == 17'd0)
        else $error("failure result malformed");

    // Pixels only come from a good header
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.pixel_valid |->
            dst_data.status == ST_OK && dst_data.image_width != 17'd0 &&
            dst_data.image_height != 17'd0)
        else $error("pixel from bad or empty image");

    // The last pixel of the image ends its run
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.pixel_valid && dst_data.image_done |->
            dst_data.last_of_run)
        else $error("image ended inside a run");

endmodule

bind pcx_rle_palette_decoder_unit pcx_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data)
);

`default_nettype wire

### test/pcx_rle_palette_decoder_unit_tb.sv
module pcx_rle_palette_decoder_unit_tb;
    import pcx_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int ITEM_TARGET     = 470;
    localparam int IDLE_PCT        = 29;
    localparam int QUIET_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 20;

    // One step of the directed plan: a single request or a whole valid header
    typedef struct {
        bit          is_header;
        logic [63:0] bounds;    // {ymax, xmax, ymin, xmin}
        in_item_t    req;
        bit          typed;
        out_item_t   want;
    } plan_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      src_valid;
    logic      src_ready;
    in_item_t  src_data;
    logic      dst_valid;
    logic      dst_ready;
    out_item_t dst_data;

    bit        steady;        // no idling on either side while set
    bit        want_typed;    // request in flight carries a typed-in result
    out_item_t want_result;
    int        sent;
    int        fails;
    int        quiet;

    // Decoder mirror
    logic [23:0] pal_rgb [PALETTE_ENTRIES];
    bit          pal_loaded [PALETTE_ENTRIES];
    int          hdr_pos;
    logic [63:0] bound_bytes;
    logic [32:0] pixels_left;
    bit          run_armed;
    logic [5:0]  run_len;
    bit          hdr_failed;

    out_item_t   step_results [$];
    out_item_t   decoded_due [$];
    out_item_t   head_result;
    plan_row_t   directed_plan [$];

    pcx_rle_palette_decoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        dst_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [16:0] dim_span(logic [15:0] lo, logic [15:0] hi);
        return (hi < lo) ? 17'd0 : 17'(hi) - 17'(lo) + 17'd1;
    endfunction

    function automatic out_item_t status_result(logic [1:0] st, bit done,
                                                logic [16:0] w, logic [16:0] h);
        out_item_t o;
        o = '0;
        o.last_of_run  = 1'b1;
        o.image_done   = done;
        o.status       = st;
        o.image_width  = w;
        o.image_height = h;
        return o;
    endfunction

    function automatic out_item_t make_result(bit pix, logic [23:0] rgb, bit last,
                                              bit done, logic [1:0] st);
        out_item_t o;
        logic [16:0] w;
        logic [16:0] h;
        w = 17'd0;
        h = 17'd0;
        // size reads as zero until the header is complete
        if (hdr_pos >= HEADER_BYTES)
        begin
            w = dim_span(bound_bytes[15:0], bound_bytes[47:32]);
            h = dim_span(bound_bytes[31:16], bound_bytes[63:48]);
        end
        o = status_result(st, done, w, h);
        o.pixel_valid = pix;
        o.last_of_run = last;
        {o.red, o.green, o.blue} = rgb;
        return o;
    endfunction

    function automatic void open_image();
        hdr_pos     = 0;
        bound_bytes = '0;
        pixels_left = '0;
        run_armed   = 1'b0;
        run_len     = '0;
        hdr_failed  = 1'b0;
    endfunction

    // Work out the results one accepted request causes
    function automatic void decode_request(in_item_t r);
        logic [7:0]  c;
        logic [32:0] n;
        logic [23:0] rgb;
        int          pos;
        int          k;
        c = r.file_byte;
        if (r.mode == MODE_PALETTE)
        begin
            pal_rgb[r.palette_index]    = {r.palette_red, r.palette_green, r.palette_blue};
            pal_loaded[r.palette_index] = 1'b1;
            return;
        end
        if (r.mode == MODE_OPEN)
        begin
            open_image();
            return;
        end
        if (r.mode != MODE_BYTE || hdr_failed)
            return;

        // header bytes
        if (hdr_pos < HEADER_BYTES)
        begin
            pos = hdr_pos;
            if ((pos == 0 && c != MAGIC_BYTE) || (pos == 1 && c != VERSION_BYTE))
            begin
                hdr_failed = 1'b1;
                step_results.push_back(make_result(1'b0, 24'd0, 1'b1, 1'b0,
                                       (pos == 0) ? ST_BAD_MAGIC : ST_BAD_VERSION));
                return;
            end
            hdr_pos = pos + 1;
            if (pos >= BOUND_FIRST && pos < BOUND_END)
                bound_bytes[8 * (pos - BOUND_FIRST) +: 8] = c;
            if (hdr_pos == HEADER_BYTES)
            begin
                pixels_left = {16'd0, dim_span(bound_bytes[15:0], bound_bytes[47:32])}
                            * {16'd0, dim_span(bound_bytes[31:16], bound_bytes[63:48])};
                step_results.push_back(make_result(1'b0, 24'd0, 1'b1,
                                                   pixels_left == 0, ST_OK));
            end
            return;
        end

        // pixel data; bytes past the image are dropped
        if (pixels_left == 0)
            return;
        if (run_armed)
        begin
            run_armed = 1'b0;
            n = {27'd0, run_len};
            if (n > pixels_left)
                n = pixels_left;
        end
        else if (c > RUN_MARK)
        begin
            run_armed = 1'b1;
            run_len   = c[5:0] & RUN_MASK[5:0];
            return;
        end
        else
            n = 33'd1;
        rgb = pal_rgb[c];
        for (k = 0; k < n; k++)
        begin
            pixels_left = pixels_left - 33'd1;
            step_results.push_back(make_result(1'b1, rgb, k + 1 == n,
                                               pixels_left == 0, ST_OK));
        end
    endfunction

    function automatic in_item_t noise_req();
        logic [63:0] bits;
        in_item_t    r;
        bits = {$urandom, $urandom};
        r = bits[$bits(in_item_t)-1:0];
        return r;
    endfunction

    function automatic in_item_t byte_req(logic [7:0] b);
        in_item_t r;
        r = noise_req();
        r.mode      = MODE_BYTE;
        r.file_byte = b;
        return r;
    endfunction

    function automatic in_item_t pal_req(logic [7:0] idx, logic [23:0] rgb);
        in_item_t r;
        r = noise_req();
        r.mode          = MODE_PALETTE;
        r.palette_index = idx;
        {r.palette_red, r.palette_green, r.palette_blue} = rgb;
        return r;
    endfunction

    function automatic in_item_t ctl_req(logic [1:0] mode);
        in_item_t r;
        r = noise_req();
        r.mode = mode;
        return r;
    endfunction

    function automatic plan_row_t req_row(in_item_t r, bit typed, out_item_t want);
        plan_row_t s;
        s.is_header = 1'b0;
        s.bounds    = '0;
        s.req       = r;
        s.typed     = typed;
        s.want      = want;
        return s;
    endfunction

    function automatic plan_row_t hdr_row(logic [15:0] x0, logic [15:0] y0, logic [15:0] x1,
                                          logic [15:0] y1, out_item_t want);
        plan_row_t s;
        s.is_header = 1'b1;
        s.bounds    = {y1, x1, y0, x0};
        s.req       = '0;
        s.typed     = 1'b1;
        s.want      = want;
        return s;
    endfunction

    // Palette index that has been loaded, so no undefined color is ever read
    function automatic logic [7:0] pick_color_index(bit literal_only);
        logic [7:0] idx;
        int         t;
        for (t = 0; t < 16; t++)
        begin
            idx = literal_only ? 8'($urandom_range(RUN_MARK)) : 8'($urandom);
            if (pal_loaded[idx])
                return idx;
        end
        return 8'd0;    // entry 0 is loaded early in the directed part
    endfunction

    function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    // Present one request at the falling edge and hold it until accepted
    task automatic send_request(in_item_t r, bit typed, out_item_t want);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid   <= 1'b1;
        src_data    <= r;
        want_typed  <= typed;
        want_result <= want;
        do
            @(posedge clk);
        while (!src_ready);
        sent++;
        @(negedge clk);
    endtask

    // Full valid header; a typed result applies to the closing byte only
    task automatic send_header(logic [63:0] bnd, bit typed, out_item_t want);
        logic [7:0] b;
        int         p;
        for (p = 0; p < HEADER_BYTES; p++)
        begin
            if (p == 0)
                b = MAGIC_BYTE;
            else if (p == 1)
                b = VERSION_BYTE;
            else if (p >= BOUND_FIRST && p < BOUND_END)
                b = bnd[8 * (p - BOUND_FIRST) +: 8];
            else
                b = 8'($urandom);
            send_request(byte_req(b), typed && (p == HEADER_BYTES - 1), want);
        end
    endtask

    // Palette touch-up, open, header (sometimes broken), pixel data, trailing junk
    task automatic send_random_image();
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [7:0]  b;
        int          pick;
        repeat ($urandom_range(2, 8))
            send_request(pal_req(8'($urandom), 24'($urandom)), 1'b0, '0);
        send_request(ctl_req(MODE_OPEN), 1'b0, '0);
        // the image with no idling always gets a good header
        pick = steady ? 99 : $urandom_range(99);
        if (pick < 12)
        begin
            b = 8'($urandom);
            if (b == MAGIC_BYTE)
                b = b + 8'd1;
            send_request(byte_req(b), 1'b0, '0);
        end
        else if (pick < 24)
        begin
            b = 8'($urandom);
            if (b == VERSION_BYTE)
                b = b + 8'd1;
            send_request(byte_req(MAGIC_BYTE), 1'b0, '0);
            send_request(byte_req(b), 1'b0, '0);
        end
        else
        begin
            // small images; a zero span inverts that bound
            x0 = 16'($urandom_range(1, 16'hFFF8));
            y0 = 16'($urandom_range(1, 16'hFFF8));
            x1 = x0 + 16'($urandom_range(0, 6)) - 16'd1;
            y1 = y0 + 16'($urandom_range(0, 6)) - 16'd1;
            send_header({y1, x1, y0, x0}, 1'b0, '0);
            while (pixels_left != 0)
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                    send_request(ctl_req(MODE_UNUSED), 1'b0, '0);
                else if (pick < 10)
                    send_request(pal_req(8'($urandom), 24'($urandom)), 1'b0, '0);
                else if (run_armed)
                    send_request(byte_req(pick_color_index(1'b0)), 1'b0, '0);
                else if (pick < 40)
                    send_request(byte_req(8'hC0 | 8'($urandom_range(0, 63))), 1'b0, '0);
                else
                    send_request(byte_req(pick_color_index(1'b1)), 1'b0, '0);
            end
        end
        repeat ($urandom_range(1, 4))
            send_request(byte_req(8'($urandom)), 1'b0, '0);
    endtask

    // Prediction on accepted requests, result check, stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && src_ready)
            begin
                step_results.delete();
                decode_request(src_data);
                if (want_typed)
                    decoded_due.push_back(want_result);
                else
                    foreach (step_results[i])
                        decoded_due.push_back(step_results[i]);
            end
            if (dst_valid && dst_ready)
            begin
                if (decoded_due.size() == 0)
                begin
                    $error("result with nothing expected: %p", dst_data);
                    fails++;
                end
                else
                begin
                    head_result = decoded_due.pop_front();
                    check_field("pixel_valid", head_result.pixel_valid, dst_data.pixel_valid);
                    check_field("red", head_result.red, dst_data.red);
                    check_field("green", head_result.green, dst_data.green);
                    check_field("blue", head_result.blue, dst_data.blue);
                    check_field("last_of_run", head_result.last_of_run, dst_data.last_of_run);
                    check_field("image_done", head_result.image_done, dst_data.image_done);
                    check_field("status", head_result.status, dst_data.status);
                    check_field("image_width", head_result.image_width, dst_data.image_width);
                    check_field("image_height", head_result.image_height,
                                dst_data.image_height);
                end
            end
            if ((src_valid && src_ready) || (dst_valid && dst_ready))
                quiet = 0;
            else
                quiet = quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("pcx_rle_palette_decoder_unit verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int img;
        rst_n       = 1'b0;
        src_valid   = 1'b0;
        src_data    = '0;
        dst_ready   = 1'b0;
        want_typed  = 1'b0;
        want_result = '0;
        steady      = 1'b0;
        sent        = 0;
        fails       = 0;
        quiet       = 0;
        foreach (pal_loaded[i])
            pal_loaded[i] = 1'b0;
        open_image();

        // Directed plan
        // bad magic straight after reset, then an ignored byte and an unused mode
        directed_plan.push_back(req_row(byte_req(8'hFF), 1'b1,
                                        status_result(ST_BAD_MAGIC, 1'b0, 17'd0, 17'd0)));
        directed_plan.push_back(req_row(byte_req(MAGIC_BYTE), 1'b0, '0));
        directed_plan.push_back(req_row(ctl_req(MODE_UNUSED), 1'b0, '0));
        // bad version byte
        directed_plan.push_back(req_row(ctl_req(MODE_OPEN), 1'b0, '0));
        directed_plan.push_back(req_row(byte_req(MAGIC_BYTE), 1'b0, '0));
        directed_plan.push_back(req_row(byte_req(8'h00), 1'b1,
                                        status_result(ST_BAD_VERSION, 1'b0, 17'd0, 17'd0)));
        // palette extremes and the entries the pixel rows read
        directed_plan.push_back(req_row(pal_req(8'h00, 24'h000000), 1'b0, '0));
        directed_plan.push_back(req_row(pal_req(8'hFF, 24'hFFFFFF), 1'b0, '0));
        directed_plan.push_back(req_row(pal_req(RUN_MARK, 24'($urandom)), 1'b0, '0));
        directed_plan.push_back(req_row(pal_req(8'hC1, 24'($urandom)), 1'b0, '0));
        // widest image: literals, longest run, zero-length run, run of one
        directed_plan.push_back(req_row(ctl_req(MODE_OPEN), 1'b0, '0));
        directed_plan.push_back(hdr_row(16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
                                        status_result(ST_OK, 1'b0, 17'd65536, 17'd1)));
        directed_plan.push_back(req_row(byte_req(8'h00), 1'b0, '0));
        directed_plan.push_back(req_row(byte_req(RUN_MARK), 1'b0, '0));
        directed_plan.push_back(req_row(byte_req(8'hFF), 1'b0, '0));
        directed_plan.push_back(req_row(byte_req(8'hFF), 1'b0, '0));
        directed_plan.push_back(req_row(byte_req(8'hC0), 1'b0, '0));
        directed_plan.push_back(req_row(byte_req(8'hC1), 1'b0, '0));
        directed_plan.push_back(req_row(byte_req(8'hC1), 1'b0, '0));
        directed_plan.push_back(req_row(byte_req(8'hC1), 1'b0, '0));
        // inverted x bounds: empty image, trailing byte dropped
        directed_plan.push_back(req_row(ctl_req(MODE_OPEN), 1'b0, '0));
        directed_plan.push_back(hdr_row(16'd5, 16'd0, 16'd4, 16'd0,
                                        status_result(ST_OK, 1'b1, 17'd0, 17'd1)));
        directed_plan.push_back(req_row(byte_req(8'h00), 1'b0, '0));
        // run clamped at the two remaining pixels, then a dropped byte
        directed_plan.push_back(req_row(ctl_req(MODE_OPEN), 1'b0, '0));
        directed_plan.push_back(hdr_row(16'd2, 16'd7, 16'd3, 16'd7,
                                        status_result(ST_OK, 1'b0, 17'd2, 17'd1)));
        directed_plan.push_back(req_row(byte_req(8'hC5), 1'b0, '0));
        directed_plan.push_back(req_row(byte_req(8'hFF), 1'b0, '0));
        directed_plan.push_back(req_row(byte_req(8'h00), 1'b0, '0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_header)
                send_header(directed_plan[i].bounds, directed_plan[i].typed,
                            directed_plan[i].want);
            else
                send_request(directed_plan[i].req, directed_plan[i].typed,
                             directed_plan[i].want);
        end

        // Random images up to the request budget; the first one runs with no idling
        img = 0;
        while (sent < ITEM_TARGET)
        begin
            steady = (img == 0);
            send_random_image();
            img++;
        end
        steady = 1'b0;
        src_valid <= 1'b0;

        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("pcx_rle_palette_decoder_unit verification clean");
        else
            $display("pcx_rle_palette_decoder_unit verification failed");
        $finish;
    end

endmodule
